FILE: sv/lcm_pkg.sv
`timescale 1ns / 1ps
// lcm_pkg: shared constants for the lcm_two_unsigned block
// no dependencies
package lcm_pkg;

  localparam int unsigned OPND_W      = 32;  // width of each operand field
  localparam int unsigned RES_W       = 64;  // width of the result field
  localparam int unsigned IN_TDATA_W  = 2 * OPND_W;
  localparam int unsigned OUT_TDATA_W = RES_W;

endpackage

FILE: sv/lcm_two_unsigned.sv
`timescale 1ns / 1ps
// lcm_two_unsigned: least common multiple of two unsigned operands
// depends on lcm_pkg
//
// usage
//   input channel in_*: one transfer carries both operands, a in the low half
//   of in_tdata and b in the high half. only the low OPERAND_WIDTH bits of
//   each operand are used. result channel out_*: one transfer per input
//   transfer carries lcm(a, b), or 0 when either operand is zero.
//   one shared adder/subtractor does all the arithmetic under a small
//   sequencer: a binary gcd (one shift or subtract-and-halve per cycle),
//   a restoring divide a / gcd and a shift-add multiply by b, then the
//   result is loaded into the output register. a zero operand skips
//   straight to that load. in_tready is high only while the sequencer is
//   idle, so the next item is accepted in the cycle after the load at
//   earliest. the output register lets the next item be accepted while a
//   result still waits; if the receiver stalls, the finished item waits in
//   the sequencer until the output register frees up.
//   reset (rst_n low, synchronous) empties the output register and returns
//   the sequencer to idle.
module lcm_two_unsigned
  import lcm_pkg::*;
#(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // first_operand [31:0], second_operand [63:32]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // least_multiple [63:0]
);

  localparam int unsigned W  = OPERAND_WIDTH;
  localparam int unsigned AW = W + 1;
  localparam int unsigned KW = (W > 2) ? $clog2(W) : 1;
  localparam int unsigned CW = $clog2(W + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_GCD  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]             state_r, state_nxt;
  logic [W-1:0]           opa_r, opa_nxt;
  logic [W-1:0]           opb_r, opb_nxt;
  logic [W-1:0]           x_r, x_nxt;
  logic [W-1:0]           y_r, y_nxt;
  logic [W-1:0]           g_r, g_nxt;
  logic [KW-1:0]          k_r, k_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  // shared adder / subtractor
  logic [AW-1:0] au_a, au_b;
  logic          au_sub;
  logic [AW:0]   au_sum;

  logic [W-1:0]  in_a, in_b;
  logic          x_lt_y;
  logic [AW-1:0] rem_sh;

  assign au_sum = {1'b0, au_a} + {1'b0, (au_sub ? ~au_b : au_b)} + (AW + 1)'(au_sub);

  assign in_a   = in_tdata[W-1:0];
  assign in_b   = in_tdata[OPND_W +: W];
  assign x_lt_y = (x_r < y_r);
  assign rem_sh = {x_r, y_r[W-1]};

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    au_a   = '0;
    au_b   = '0;
    au_sub = 1'b0;
    case (state_r)
      ST_GCD: begin
        au_a   = x_lt_y ? {1'b0, y_r} : {1'b0, x_r};
        au_b   = x_lt_y ? {1'b0, x_r} : {1'b0, y_r};
        au_sub = 1'b1;
      end
      ST_DIV: begin
        au_a   = rem_sh;
        au_b   = {1'b0, g_r};
        au_sub = 1'b1;
      end
      ST_MUL: begin
        au_a   = {1'b0, x_r};
        au_b   = y_r[0] ? {1'b0, opb_r} : '0;
        au_sub = 1'b0;
      end
      default: begin
        au_a   = '0;
        au_b   = '0;
        au_sub = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    opa_nxt       = opa_r;
    opb_nxt       = opb_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    g_nxt         = g_r;
    k_nxt         = k_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          opa_nxt = in_a;
          opb_nxt = in_b;
          x_nxt   = in_a;
          y_nxt   = in_b;
          k_nxt   = '0;
          if ((in_a == '0) || (in_b == '0)) begin
            x_nxt     = '0;
            y_nxt     = '0;
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_GCD;
          end
        end
      end
      ST_GCD: begin
        if (!x_r[0] && !y_r[0]) begin
          x_nxt = x_r >> 1;
          y_nxt = y_r >> 1;
          k_nxt = k_r + 1'b1;
        end else if (!x_r[0]) begin
          x_nxt = x_r >> 1;
        end else if (!y_r[0]) begin
          y_nxt = y_r >> 1;
        end else if (x_r == y_r) begin
          g_nxt     = x_r << k_r;
          x_nxt     = '0;
          y_nxt     = opa_r;
          cnt_nxt   = CW'(W);
          state_nxt = ST_DIV;
        end else if (x_lt_y) begin
          y_nxt = au_sum[W:1];
        end else begin
          x_nxt = au_sum[W:1];
        end
      end
      ST_DIV: begin
        // restoring divide: remainder in x, quotient shifts into y
        x_nxt   = au_sum[AW] ? au_sum[W-1:0] : rem_sh[W-1:0];
        y_nxt   = {y_r[W-2:0], au_sum[AW]};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          x_nxt     = '0;
          cnt_nxt   = CW'(W);
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        // shift-add multiply: high half in x, low half and multiplier in y
        x_nxt   = au_sum[W:1];
        y_nxt   = {au_sum[0], y_r[W-1:1]};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_TDATA_W'({x_r, y_r});
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    opa_r      <= opa_nxt;
    opb_r      <= opb_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    g_r        <= g_nxt;
    k_r        <= k_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
  end

  // gcd operands never reach zero while reducing
  a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_GCD) |-> ((x_r != '0) && (y_r != '0)))
    else $error("gcd operand reached zero");

  // divisor is never zero during the divide
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (g_r != '0))
    else $error("zero divisor in divide phase");

  // an accepted item always starts work
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_GCD || state_r == ST_FIN))
    else $error("accepted item did not start");

  // output register empties after a transfer unless refilled
  a_out_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_tready && state_r != ST_FIN) |=> !out_valid_r)
    else $error("output held after transfer");

  // a finished item is loaded as soon as the output register can take it
  a_fin_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && !out_valid_r) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("finished item not loaded");

endmodule

FILE: dv/lcm_checker.sv
`timescale 1ns / 1ps
// lcm_checker: watches both stream channels of lcm_two_unsigned, predicts each lcm
// and compares every result transfer with the oldest prediction
// depends on lcm_pkg
module lcm_checker
  import lcm_pkg::*;
#(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // first_operand [31:0], second_operand [63:32]
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,  // least_multiple [63:0]
  output int unsigned            mismatch_count,
  output int unsigned            pending_count
);

  logic [RES_W-1:0] lcm_expected[$];

  initial mismatch_count = 0;
  initial pending_count  = 0;

  // euclid on the masked operands, zero when either operand is zero
  function automatic logic [RES_W-1:0] lcm_of(logic [OPND_W-1:0] a_raw,
                                                logic [OPND_W-1:0] b_raw);
    logic [RES_W-1:0] mask;
    logic [RES_W-1:0] a;
    logic [RES_W-1:0] b;
    logic [RES_W-1:0] x;
    logic [RES_W-1:0] y;
    logic [RES_W-1:0] r;
    mask = {RES_W{1'b1}} >> (RES_W - OPERAND_WIDTH);
    a = RES_W'(a_raw);
    b = RES_W'(b_raw);
    a = a & mask;
    b = b & mask;
    if (a == 0 || b == 0) return '0;
    x = a;
    y = b;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    return (a / x) * b;
  endfunction

  task automatic report_mismatch(string what, logic [RES_W-1:0] got, logic [RES_W-1:0] want);
    $display("%0t ns lcm_checker: %s, got %h, want %h", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    logic [RES_W-1:0] want;
    if (rst_n) begin
      if (in_tvalid && in_tready)
        lcm_expected = {lcm_expected,
                        lcm_of(in_tdata[OPND_W-1:0], in_tdata[2*OPND_W-1:OPND_W])};
      if (out_tvalid && out_tready) begin
        if (lcm_expected.size() == 0) begin
          report_mismatch("result transfer with nothing outstanding", out_tdata, '0);
        end else begin
          want = lcm_expected.pop_front();
          if (out_tdata !== want)
            report_mismatch("least_multiple differs", out_tdata, want);
        end
      end
    end
    pending_count <= lcm_expected.size();
  end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// testbench: drives operand pairs into lcm_two_unsigned under random idling on both sides
// depends on lcm_pkg, lcm_two_unsigned and lcm_checker
module testbench;
  import lcm_pkg::*;

  localparam int unsigned RANDOM_PER_PHASE = 200;
  localparam int unsigned DRAIN_CYCLES     = 4 * OPND_W + 20;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // first_operand [31:0], second_operand [63:32]
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // least_multiple [63:0]
  int unsigned            mismatch_count;
  int unsigned            pending_count;
  int unsigned            send_idle_pct;
  int unsigned            recv_stall_pct;

  lcm_two_unsigned dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  lcm_checker u_lcm_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .mismatch_count(mismatch_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_operands(logic [OPND_W-1:0] a, logic [OPND_W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {b, a};
    do @(posedge clk); while (!in_tready);
  endtask

  // random magnitude: anywhere from one to OPND_W significant bits
  function automatic logic [OPND_W-1:0] ranged_operand();
    return $urandom >> $urandom_range(OPND_W - 1);
  endfunction

  task automatic send_random_pair();
    logic [OPND_W-1:0] a;
    logic [OPND_W-1:0] b;
    logic [OPND_W-1:0] g;
    case ($urandom_range(9))
      0, 1, 2: begin
        a = $urandom;
        b = $urandom;
      end
      3, 4: begin
        g = ranged_operand();
        a = g * $urandom_range(1, 5000);
        b = g * $urandom_range(1, 5000);
      end
      5: begin
        a = $urandom_range(1, 1000);
        b = $urandom_range(1, 1000);
      end
      6: begin
        a = ranged_operand();
        b = ranged_operand();
      end
      7: begin
        a = ranged_operand();
        b = a * $urandom_range(1, 64);
        if ($urandom_range(1)) {a, b} = {b, a};
      end
      8: begin
        a = '0;
        b = '0;
        a[$urandom_range(OPND_W - 1)] = 1'b1;
        b[$urandom_range(OPND_W - 1)] = 1'b1;
        if ($urandom_range(1)) b = b | $urandom_range(0, 255);
      end
      default: begin
        // zero operand on either side
        a = $urandom_range(1) ? $urandom : '0;
        b = '0;
        if ($urandom_range(1)) {a, b} = {b, a};
      end
    endcase
    send_operands(a, b);
  endtask

  initial begin
    in_tvalid      <= 1'b0;
    in_tdata       <= '0;
    out_tready     <= 1'b0;
    rst_n          <= 1'b0;
    send_idle_pct  = 34;
    recv_stall_pct = 54;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero operands, extremes, near-2^64 products, powers of two, long euclid chains
    send_operands(32'd0, 32'd0);
    send_operands(32'd0, 32'hFFFF_FFFF);
    send_operands(32'hFFFF_FFFF, 32'd0);
    send_operands(32'd1, 32'd1);
    send_operands(32'd1, 32'hFFFF_FFFF);
    send_operands(32'hFFFF_FFFF, 32'd1);
    send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFE);
    send_operands(32'hFFFF_FFFB, 32'hFFFF_FFEF);
    send_operands(32'h8000_0000, 32'h8000_0000);
    send_operands(32'h8000_0000, 32'd1);
    send_operands(32'h8000_0000, 32'd3);
    send_operands(32'd12, 32'd18);
    send_operands(32'd21, 32'd6);
    send_operands(32'd7, 32'd7);
    send_operands(32'd6, 32'd35);
    send_operands(32'hAAAA_AAAA, 32'h5555_5555);
    send_operands(32'h5555_5555, 32'hAAAA_AAAA);
    send_operands(32'd46368, 32'd28657);
    send_operands(32'd2971215073, 32'd1836311903);
    send_operands(32'h0001_0000, 32'h0030_0000);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 34;
          recv_stall_pct = 54;
        end
        1: begin
          send_idle_pct  = 54;
          recv_stall_pct = 34;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      repeat (RANDOM_PER_PHASE) send_random_pair();
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("lcm_two_unsigned: match");
    end else begin
      $display("lcm_two_unsigned: mismatch");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("lcm_two_unsigned: mismatch");
    $finish;
  end

endmodule
